/* hdl/ecpsm_pkg.sv */
// ----------------------------------------------------------------------------
// ecpsm_pkg
// Shared types and codes for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecpsm_pkg;

   // Operations of the bit-serial field unit.
   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_MOD,
      ALU_INV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic fail;
   } alu_sts_type;

   // Configuration register indexes.
   localparam logic CSR_PRIME   = 1'b0;
   localparam logic CSR_CURVE_A = 1'b1;

endpackage

/* hdl/ecpsm_alu.sv */
// ----------------------------------------------------------------------------
// ecpsm_alu
// Bit-serial modular arithmetic unit: add, subtract, multiply, reduce and
// extended-Euclid inverse modulo m.
// ----------------------------------------------------------------------------
module ecpsm_alu #(
   parameter int FIELD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ecpsm_pkg::alu_ctl_type  ctl,
   input  logic [FIELD_BITS-1:0]   op_u,
   input  logic [FIELD_BITS-1:0]   op_v,
   input  logic [FIELD_BITS-1:0]   modulus,
   output ecpsm_pkg::alu_sts_type  sts,
   output logic [FIELD_BITS-1:0]   result
);

   localparam int W  = FIELD_BITS;
   localparam int CW = $clog2(W);

   typedef enum logic [2:0] {
      A_IDLE,
      A_MOD,
      A_MDBL,
      A_MADD,
      A_ITEST,
      A_IDIV,
      A_IQFIX,
      A_IUPD
   } alu_state_type;

   alu_state_type   state_ff;
   logic [CW-1:0]   cnt_ff;
   logic [W-1:0]    acc_ff;
   logic [W-1:0]    sh_ff;
   logic [W-1:0]    mu_ff;
   logic [W-1:0]    r0_ff, r1_ff, t0_ff, t1_ff, q_ff, rem_ff;
   logic            inv_ff;
   logic            done_ff, fail_ff;
   logic [W-1:0]    res_ff;
   logic [W:0]      trial;
   logic [W:0]      mtrial;

   function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] mm);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, mm}) s = s - {1'b0, mm};
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] mm);
      return (x >= y) ? (x - y) : (x + (mm - y));
   endfunction

   // Restoring steps for the Euclid quotient and for reduction.
   assign trial  = {rem_ff, r0_ff[W-1]};
   assign mtrial = {acc_ff, sh_ff[W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
         fail_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (ctl.start) begin
                  fail_ff <= 1'b0;
                  cnt_ff  <= CW'(W - 1);
                  acc_ff  <= '0;
                  inv_ff  <= 1'b0;
                  case (ctl.op)
                     ecpsm_pkg::ALU_ADD: begin
                        res_ff  <= add_m(op_u, op_v, modulus);
                        done_ff <= 1'b1;
                     end
                     ecpsm_pkg::ALU_SUB: begin
                        res_ff  <= sub_m(op_u, op_v, modulus);
                        done_ff <= 1'b1;
                     end
                     ecpsm_pkg::ALU_MUL: begin
                        mu_ff    <= op_u;
                        sh_ff    <= op_v;
                        state_ff <= A_MDBL;
                     end
                     ecpsm_pkg::ALU_MOD: begin
                        sh_ff    <= op_u;
                        state_ff <= A_MOD;
                     end
                     default: begin
                        r0_ff    <= modulus;
                        r1_ff    <= op_u;
                        t0_ff    <= '0;
                        t1_ff    <= W'(1);
                        state_ff <= A_ITEST;
                     end
                  endcase
               end
            end
            A_MOD: begin
               if (mtrial >= {1'b0, modulus}) begin
                  acc_ff <= W'(mtrial - {1'b0, modulus});
               end else begin
                  acc_ff <= mtrial[W-1:0];
               end
               sh_ff <= sh_ff << 1;
               if (cnt_ff == '0) begin
                  res_ff   <= (mtrial >= {1'b0, modulus}) ?
                              W'(mtrial - {1'b0, modulus}) : mtrial[W-1:0];
                  done_ff  <= 1'b1;
                  state_ff <= A_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            A_MDBL: begin
               acc_ff   <= add_m(acc_ff, acc_ff, modulus);
               state_ff <= A_MADD;
            end
            A_MADD: begin
               if (sh_ff[W-1]) acc_ff <= add_m(acc_ff, mu_ff, modulus);
               sh_ff <= sh_ff << 1;
               if (cnt_ff == '0) begin
                  if (inv_ff) begin
                     state_ff <= A_IUPD;
                  end else begin
                     res_ff   <= sh_ff[W-1] ? add_m(acc_ff, mu_ff, modulus) : acc_ff;
                     done_ff  <= 1'b1;
                     state_ff <= A_IDLE;
                  end
               end else begin
                  cnt_ff   <= cnt_ff - 1'b1;
                  state_ff <= A_MDBL;
               end
            end
            A_ITEST: begin
               if (r1_ff == '0) begin
                  res_ff   <= t0_ff;
                  fail_ff  <= (r0_ff != W'(1));
                  done_ff  <= 1'b1;
                  state_ff <= A_IDLE;
               end else begin
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= CW'(W - 1);
                  state_ff <= A_IDIV;
               end
            end
            A_IDIV: begin
               // The dividend r0 shifts out its top bit each cycle; it is
               // replaced by r1 in the update step.
               if (trial >= {1'b0, r1_ff}) begin
                  rem_ff <= W'(trial - {1'b0, r1_ff});
                  q_ff   <= {q_ff[W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[W-1:0];
                  q_ff   <= {q_ff[W-2:0], 1'b0};
               end
               r0_ff <= r0_ff << 1;
               if (cnt_ff == '0) begin
                  state_ff <= A_IQFIX;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            A_IQFIX: begin
               // The quotient can equal the modulus only on the first step.
               mu_ff    <= (q_ff >= modulus) ? (q_ff - modulus) : q_ff;
               sh_ff    <= t1_ff;
               acc_ff   <= '0;
               cnt_ff   <= CW'(W - 1);
               inv_ff   <= 1'b1;
               state_ff <= A_MDBL;
            end
            A_IUPD: begin
               t1_ff    <= sub_m(t0_ff, acc_ff, modulus);
               t0_ff    <= t1_ff;
               r0_ff    <= r1_ff;
               r1_ff    <= rem_ff;
               inv_ff   <= 1'b0;
               state_ff <= A_ITEST;
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign sts.done = done_ff;
   assign sts.fail = fail_ff;
   assign result   = res_ff;

endmodule

/* hdl/ec_point_scalar_multiply.sv */
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply
// Affine double-and-add scalar multiplication over a prime field.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time: scalar n and base point G, and
// returns n*G on y^2 = x^3 + a*x + b mod p, with flags for the point at
// infinity and for a denominator without inverse or a modulus below two.
// All field arithmetic runs in one bit-serial unit. An inverse runs, per
// Euclid step, a bit-serial division and then a multiply. Scalar bits above
// the leading one bit need no field arithmetic. Every later bit costs a
// doubling (six multiplies and one inverse) and, for a one bit, an addition
// (three multiplies and one inverse). A new transaction is accepted once the
// previous result sits in the output register.
// ----------------------------------------------------------------------------
module ec_point_scalar_multiply #(
   parameter int FIELD_BITS  = 32,
   parameter int SCALAR_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // scalar, base_x, base_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_x, result_y
   output logic [1:0]  rsp_tuser    // at_infinity, status
);

   localparam int W  = FIELD_BITS;
   localparam int S  = SCALAR_BITS;
   localparam int SC = $clog2(S);

   typedef enum logic [4:0] {
      S_IDLE, S_RED_A, S_RED_X, S_RED_Y, S_RED_3, S_RED_2,
      S_PT_BEGIN, S_YSUM, S_D1, S_D2, S_D3, S_D4, S_C1, S_C2, S_INV,
      S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_PT_END, S_OUT
   } top_state_type;

   top_state_type          state_ff;
   logic [31:0]            prime_ff, curve_a_ff;
   logic [W-1:0]           mod_ff, ca_ff, gx_ff, gy_ff, c3_ff, c2_ff;
   logic [W-1:0]           ax_ff, ay_ff, num_ff, den_ff, lam_ff, tmp_ff;
   logic                   ainf_ff, dbl_ff, err_ff, busy_ff;
   logic [S-1:0]           n_ff;
   logic [SC-1:0]          bit_ff;
   logic                   rsp_valid_ff;
   logic [31:0]            rx_ff, ry_ff;
   logic                   rinf_ff, rerr_ff;

   ecpsm_pkg::alu_ctl_type alu_ctl;
   ecpsm_pkg::alu_sts_type alu_sts;
   logic [W-1:0]           alu_u, alu_v, alu_res;
   logic [W-1:0]           p2x, p2y;
   logic [63:0]            p64, a64, x64, y64, n64, ox64, oy64;
   logic [W-1:0]           mod_in;

   assign p64    = {32'b0, prime_ff};
   assign a64    = {32'b0, curve_a_ff};
   assign n64    = {32'b0, req_tdata[31:0]};
   assign x64    = {32'b0, req_tdata[63:32]};
   assign y64    = {32'b0, req_tdata[95:64]};
   assign mod_in = p64[W-1:0];
   assign ox64   = {{(64 - W){1'b0}}, ax_ff};
   assign oy64   = {{(64 - W){1'b0}}, ay_ff};

   assign p2x = dbl_ff ? ax_ff : gx_ff;
   assign p2y = dbl_ff ? ay_ff : gy_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff   <= 32'd3;
         curve_a_ff <= 32'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ecpsm_pkg::CSR_PRIME:   prime_ff   <= csr_wr_data;
            ecpsm_pkg::CSR_CURVE_A: curve_a_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Operation and operands for each arithmetic step.
   always_comb begin
      alu_ctl.start = !busy_ff && (state_ff != S_IDLE) && (state_ff != S_PT_BEGIN)
                      && (state_ff != S_PT_END) && (state_ff != S_OUT);
      alu_ctl.op = ecpsm_pkg::ALU_ADD;
      alu_u      = '0;
      alu_v      = '0;
      case (state_ff)
         S_RED_A: begin alu_ctl.op = ecpsm_pkg::ALU_MOD; alu_u = ca_ff; end
         S_RED_X: begin alu_ctl.op = ecpsm_pkg::ALU_MOD; alu_u = gx_ff; end
         S_RED_Y: begin alu_ctl.op = ecpsm_pkg::ALU_MOD; alu_u = gy_ff; end
         S_RED_3: begin alu_ctl.op = ecpsm_pkg::ALU_MOD; alu_u = W'(3); end
         S_RED_2: begin alu_ctl.op = ecpsm_pkg::ALU_MOD; alu_u = W'(2); end
         S_YSUM:  begin alu_ctl.op = ecpsm_pkg::ALU_ADD; alu_u = ay_ff; alu_v = p2y; end
         S_D1:    begin alu_ctl.op = ecpsm_pkg::ALU_MUL; alu_u = ax_ff; alu_v = ax_ff; end
         S_D2:    begin alu_ctl.op = ecpsm_pkg::ALU_MUL; alu_u = c3_ff; alu_v = num_ff; end
         S_D3:    begin alu_ctl.op = ecpsm_pkg::ALU_ADD; alu_u = num_ff; alu_v = ca_ff; end
         S_D4:    begin alu_ctl.op = ecpsm_pkg::ALU_MUL; alu_u = c2_ff; alu_v = ay_ff; end
         S_C1:    begin alu_ctl.op = ecpsm_pkg::ALU_SUB; alu_u = p2y; alu_v = ay_ff; end
         S_C2:    begin alu_ctl.op = ecpsm_pkg::ALU_SUB; alu_u = p2x; alu_v = ax_ff; end
         S_INV:   begin alu_ctl.op = ecpsm_pkg::ALU_INV; alu_u = den_ff; end
         S_L1:    begin alu_ctl.op = ecpsm_pkg::ALU_MUL; alu_u = num_ff; alu_v = den_ff; end
         S_L2:    begin alu_ctl.op = ecpsm_pkg::ALU_MUL; alu_u = lam_ff; alu_v = lam_ff; end
         S_L3:    begin alu_ctl.op = ecpsm_pkg::ALU_SUB; alu_u = tmp_ff; alu_v = ax_ff; end
         S_L4:    begin alu_ctl.op = ecpsm_pkg::ALU_SUB; alu_u = tmp_ff; alu_v = p2x; end
         S_L5:    begin alu_ctl.op = ecpsm_pkg::ALU_SUB; alu_u = ax_ff; alu_v = tmp_ff; end
         S_L6:    begin alu_ctl.op = ecpsm_pkg::ALU_MUL; alu_u = lam_ff; alu_v = num_ff; end
         S_L7:    begin alu_ctl.op = ecpsm_pkg::ALU_SUB; alu_u = num_ff; alu_v = ay_ff; end
         default: ;
      endcase
   end

   ecpsm_alu #(.FIELD_BITS(W)) u_alu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (alu_ctl),
      .op_u    (alu_u),
      .op_v    (alu_v),
      .modulus (mod_ff),
      .sts     (alu_sts),
      .result  (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
         ainf_ff      <= 1'b1;
         dbl_ff       <= 1'b1;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;
         if (alu_ctl.start) busy_ff <= 1'b1;
         if (alu_sts.done) busy_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  mod_ff  <= mod_in;
                  ca_ff   <= a64[W-1:0];
                  gx_ff   <= x64[W-1:0];
                  gy_ff   <= y64[W-1:0];
                  n_ff    <= n64[S-1:0];
                  bit_ff  <= SC'(S - 1);
                  ainf_ff <= 1'b1;
                  dbl_ff  <= 1'b1;
                  err_ff  <= (mod_in < W'(2));
                  state_ff <= (mod_in < W'(2)) ? S_OUT : S_RED_A;
               end
            end
            S_RED_A: if (alu_sts.done) begin ca_ff <= alu_res; state_ff <= S_RED_X; end
            S_RED_X: if (alu_sts.done) begin gx_ff <= alu_res; state_ff <= S_RED_Y; end
            S_RED_Y: if (alu_sts.done) begin gy_ff <= alu_res; state_ff <= S_RED_3; end
            S_RED_3: if (alu_sts.done) begin c3_ff <= alu_res; state_ff <= S_RED_2; end
            S_RED_2: if (alu_sts.done) begin c2_ff <= alu_res; state_ff <= S_PT_BEGIN; end
            S_PT_BEGIN: begin
               if (ainf_ff) begin
                  if (!dbl_ff) begin
                     ax_ff   <= gx_ff;
                     ay_ff   <= gy_ff;
                     ainf_ff <= 1'b0;
                  end
                  state_ff <= S_PT_END;
               end else begin
                  state_ff <= S_YSUM;
               end
            end
            S_YSUM: begin
               if (alu_sts.done) begin
                  if (ax_ff == p2x && alu_res == '0) begin
                     ainf_ff  <= 1'b1;
                     state_ff <= S_PT_END;
                  end else if (ax_ff == p2x && ay_ff == p2y) begin
                     state_ff <= S_D1;
                  end else begin
                     state_ff <= S_C1;
                  end
               end
            end
            S_D1: if (alu_sts.done) begin num_ff <= alu_res; state_ff <= S_D2; end
            S_D2: if (alu_sts.done) begin num_ff <= alu_res; state_ff <= S_D3; end
            S_D3: if (alu_sts.done) begin num_ff <= alu_res; state_ff <= S_D4; end
            S_D4: if (alu_sts.done) begin den_ff <= alu_res; state_ff <= S_INV; end
            S_C1: if (alu_sts.done) begin num_ff <= alu_res; state_ff <= S_C2; end
            S_C2: if (alu_sts.done) begin den_ff <= alu_res; state_ff <= S_INV; end
            S_INV: begin
               if (alu_sts.done) begin
                  den_ff <= alu_res;
                  if (alu_sts.fail) begin
                     err_ff   <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_L1;
                  end
               end
            end
            S_L1: if (alu_sts.done) begin lam_ff <= alu_res; state_ff <= S_L2; end
            S_L2: if (alu_sts.done) begin tmp_ff <= alu_res; state_ff <= S_L3; end
            S_L3: if (alu_sts.done) begin tmp_ff <= alu_res; state_ff <= S_L4; end
            S_L4: if (alu_sts.done) begin tmp_ff <= alu_res; state_ff <= S_L5; end
            S_L5: if (alu_sts.done) begin num_ff <= alu_res; state_ff <= S_L6; end
            S_L6: if (alu_sts.done) begin num_ff <= alu_res; state_ff <= S_L7; end
            S_L7: begin
               if (alu_sts.done) begin
                  ay_ff    <= alu_res;
                  ax_ff    <= tmp_ff;
                  ainf_ff  <= 1'b0;
                  state_ff <= S_PT_END;
               end
            end
            S_PT_END: begin
               if (dbl_ff && n_ff[S-1]) begin
                  dbl_ff   <= 1'b0;
                  state_ff <= S_PT_BEGIN;
               end else if (bit_ff == '0) begin
                  state_ff <= S_OUT;
               end else begin
                  bit_ff   <= bit_ff - 1'b1;
                  n_ff     <= n_ff << 1;
                  dbl_ff   <= 1'b1;
                  state_ff <= S_PT_BEGIN;
               end
            end
            S_OUT: begin
               // The output register must be free before the result lands.
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rerr_ff      <= err_ff;
                  rinf_ff      <= !err_ff && ainf_ff;
                  rx_ff        <= (err_ff || ainf_ff) ? 32'd0 : ox64[31:0];
                  ry_ff        <= (err_ff || ainf_ff) ? 32'd0 : oy64[31:0];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {ry_ff, rx_ff};
   assign rsp_tuser  = {rerr_ff, rinf_ff};

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("infinity and error flagged together");

   a_flag_zero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1])) |-> (rsp_tdata == 64'd0))
      else $error("flagged result carries coordinates");

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      alu_sts.done |-> busy_ff)
      else $error("field unit finished without a pending operation");
`endif

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
// Directed rows set the curve (modulus and coefficient a) and send points that
// cover the special cases: zero scalar, unreduced operands, degenerate,
// composite and even moduli, and doubling a point with y = 0. A random part
// follows, with mostly short scalars so that the run stays short. Results are
// checked against a row's given values or a point-arithmetic predictor here.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          SCALAR_WIDTH = 32;
   localparam longint      CYCLE_LIMIT  = 60_000_000;
   localparam int          RANDOM_ITEMS = 100;
   localparam logic [31:0] BIG_PRIME    = 32'hFFFF_FFFB;

   typedef struct {
      logic [63:0] x;
      logic [63:0] y;
      logic        inf;
   } point_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        inf;
      logic        fail;
   } ec_result_type;

   typedef struct {
      logic [31:0]   prime;
      logic [31:0]   coef_a;
      logic [31:0]   scalar;
      logic [31:0]   bx;
      logic [31:0]   by;
      logic          typed;
      ec_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   ec_result_type expected_points[$];
   logic [31:0]   cur_prime;
   logic [31:0]   cur_coef_a;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            error_count = 0;
   int            sent_count;
   int            checked_count = 0;
   longint        cycle_count = 0;

   ec_point_scalar_multiply uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- field and point arithmetic ----------------
   function automatic logic [63:0] fadd(logic [63:0] u, logic [63:0] v, logic [63:0] m);
      logic [63:0] s;
      s = u + v;
      if (s >= m) s = s - m;
      return s;
   endfunction

   function automatic logic [63:0] fsub(logic [63:0] u, logic [63:0] v, logic [63:0] m);
      return (u >= v) ? (u - v) : (u + (m - v));
   endfunction

   // Operands are below 2**32, so the product fits in 64 bits.
   function automatic logic [63:0] fmul(logic [63:0] u, logic [63:0] v, logic [63:0] m);
      return (u * v) % m;
   endfunction

   function automatic logic finv(logic [63:0] u, logic [63:0] m, output logic [63:0] res);
      logic [63:0] r0, r1, t0, t1, q, tmp;
      r0 = m; r1 = u; t0 = 0; t1 = 1; res = 0;
      while (r1 != 0) begin
         q   = r0 / r1;
         tmp = r0 - q * r1;
         r0  = r1;
         r1  = tmp;
         tmp = fsub(t0, fmul(q % m, t1, m), m);
         t0  = t1;
         t1  = tmp;
      end
      if (r0 != 1) return 1'b0;
      res = t0;
      return 1'b1;
   endfunction

   function automatic point_type point_sum(point_type p1, point_type p2, logic [63:0] m,
                                           logic [63:0] a, inout logic fail);
      point_type   r;
      logic [63:0] num, den, inv, lam, t;
      r.x = 0; r.y = 0; r.inf = 1'b1;
      if (p1.inf) return p2;
      if (p2.inf) return p1;
      if (p1.x == p2.x && fadd(p1.y, p2.y, m) == 0) return r;
      if (p1.x == p2.x && p1.y == p2.y) begin
         num = fadd(fmul(3 % m, fmul(p1.x, p1.x, m), m), a, m);
         den = fmul(2 % m, p1.y, m);
      end else begin
         num = fsub(p2.y, p1.y, m);
         den = fsub(p2.x, p1.x, m);
      end
      if (!finv(den, m, inv)) begin
         fail = 1'b1;
         return r;
      end
      lam = fmul(num, inv, m);
      t   = fsub(fsub(fmul(lam, lam, m), p1.x, m), p2.x, m);
      r.y = fsub(fmul(lam, fsub(p1.x, t, m), m), p1.y, m);
      r.x = t;
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic ec_result_type scalar_multiple(logic [31:0] n, logic [31:0] bx,
                                                     logic [31:0] by);
      ec_result_type res;
      point_type     g, acc;
      logic [63:0]   m, a;
      logic          fail;
      res = '0;
      m = {32'd0, cur_prime};
      if (m < 2) begin
         res.fail = 1'b1;
         return res;
      end
      a = cur_coef_a % m;
      g.x = bx % m; g.y = by % m; g.inf = 1'b0;
      acc.x = 0; acc.y = 0; acc.inf = 1'b1;
      fail = 1'b0;
      for (int i = SCALAR_WIDTH - 1; i >= 0 && !fail; i--) begin
         acc = point_sum(acc, acc, m, a, fail);
         if (!fail && n[i]) acc = point_sum(acc, g, m, a, fail);
      end
      if (fail) res.fail = 1'b1;
      else if (acc.inf) res.inf = 1'b1;
      else begin
         res.x = acc.x[31:0];
         res.y = acc.y[31:0];
      end
      return res;
   endfunction

   // ---------------- stimulus tasks ----------------
   task automatic write_reg(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Registers change only with nothing in flight.
   task automatic set_curve(logic [31:0] prime, logic [31:0] coef_a);
      wait (expected_points.size() == 0);
      repeat (8) @(posedge clock);
      if (prime != cur_prime) write_reg(ecpsm_pkg::CSR_PRIME, prime);
      if (coef_a != cur_coef_a) write_reg(ecpsm_pkg::CSR_CURVE_A, coef_a);
      cur_prime  = prime;
      cur_coef_a = coef_a;
   endtask

   task automatic send_point(logic [31:0] n, logic [31:0] bx, logic [31:0] by,
                             logic typed, ec_result_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {by, bx, n};
      do @(posedge clock); while (!req_tready);
      expected_points.push_back(typed ? want : scalar_multiple(n, bx, by));
      sent_count++;
   endtask

   function automatic logic [31:0] pick_prime();
      logic [31:0] small_primes[8] = '{5, 7, 11, 13, 17, 97, 251, 65521};
      case ($urandom_range(5))
         0, 1, 2: return small_primes[$urandom_range(7)];
         3:       return BIG_PRIME;
         4:       return $urandom_range(200, 4);         // composite or even too
         default: return $urandom | 32'd1;
      endcase
   endfunction

   // Short scalars keep a transaction cheap; full-width ones only on small fields.
   function automatic logic [31:0] pick_scalar();
      int width;
      if (cur_prime < 1000 && $urandom_range(9) == 0) return $urandom;
      width = $urandom_range(6);
      return $urandom & ((32'd1 << width) - 1);
   endfunction

   // ---------------- result checking ----------------
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      ec_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_count++;
         if (expected_points.size() == 0) begin
            $error("result without a pending transaction: x=%h y=%h user=%b",
                   rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_tdata[31:0] !== want.x) begin
               $error("result_x: expected %h, got %h", want.x, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== want.y) begin
               $error("result_y: expected %h, got %h", want.y, rsp_tdata[63:32]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.inf) begin
               $error("at_infinity: expected %b, got %b", want.inf, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[1] !== want.fail) begin
               $error("status: expected %b, got %b", want.fail, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results pending", expected_points.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      stim_row_type  rows[$];
      ec_result_type none;
      logic [31:0]   n;
      none = '0;
      rows = '{
         '{32'd3, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
         '{32'd3, 32'd0, 32'd1, 32'd1, 32'd1, 1'b0, '0},
         '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
         '{32'd3, 32'd0, 32'd1, 32'd5, 32'd0, 1'b1, '{32'd2, 32'd0, 1'b0, 1'b0}},
         '{32'd3, 32'd0, 32'd2, 32'd1, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
         '{32'd0, 32'd0, 32'd5, 32'd1, 32'd2, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
         '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd2, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
         '{32'd15, 32'd1, 32'd7, 32'd2, 32'd3, 1'b0, '0},
         '{32'd15, 32'd1, 32'd2, 32'd6, 32'd5, 1'b0, '0},
         '{32'd4, 32'd1, 32'd3, 32'd1, 32'd1, 1'b0, '0},
         '{32'd97, 32'd2, 32'd5, 32'd3, 32'd6, 1'b0, '0},
         '{32'd97, 32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
         '{32'd97, 32'hFFFF_FFFF, 32'h8000_0001, 32'd17, 32'd10, 1'b0, '0},
         '{BIG_PRIME, 32'd7, 32'd3, 32'd123456789, 32'd987654321, 1'b0, '0},
         '{BIG_PRIME, 32'd0, 32'd2, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
         '{32'hFFFF_FFFF, 32'd0, 32'd6, 32'hFFFF_FFFE, 32'h1234_5678, 1'b0, '0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd5, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0}
      };
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = ecpsm_pkg::CSR_PRIME;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      cur_prime = 32'd3;
      cur_coef_a = 32'd0;
      send_idle_pct = 11;
      recv_idle_pct = 68;
      sent_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         if (rows[i].prime != cur_prime || rows[i].coef_a != cur_coef_a) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            set_curve(rows[i].prime, rows[i].coef_a);
         end
         send_point(rows[i].scalar, rows[i].bx, rows[i].by, rows[i].typed, rows[i].want);
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 11;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (k % 12 == 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            set_curve(pick_prime(), ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
         end
         n = pick_scalar();
         send_point(n, $urandom, $urandom, 1'b0, none);
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      wait (expected_points.size() == 0);
      repeat (100) @(posedge clock);
      $display("%0d points multiplied, %0d results checked, over several curves",
               sent_count, checked_count);
      $display("moduli included zero, one, even, composite and near 2**32");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* ec_point_scalar_multiply.f */
hdl/ecpsm_pkg.sv
hdl/ecpsm_alu.sv
hdl/ec_point_scalar_multiply.sv
tb/sv/tb_top.sv
